### rtl/utu_pkg.sv
// ----------------------------------------------------------------------------
// utu_pkg
// Shared widths, constants and the result type of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utu_pkg;

  localparam int ByteW  = 8;
  localparam int UnitW  = 16;
  localparam int CountW = 16;

  localparam logic [CountW-1:0] MaxCharsReset = 16'd255;
  localparam logic [UnitW-1:0]  BadUnit       = 16'hFFFF;

  typedef struct packed {
    logic [UnitW-1:0]  code_unit;
    logic              bad_sequence;
    logic              string_end;
    logic [CountW-1:0] char_count;
  } result_t;

endpackage

### rtl/utu_decode.sv
// ----------------------------------------------------------------------------
// utu_decode
// Per-byte string state and single-pass decode of one registered byte.
// ----------------------------------------------------------------------------
module utu_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [utu_pkg::ByteW-1:0]   byte_in,
  input  logic [utu_pkg::CountW-1:0]  max_chars,
  output logic                        res_valid,
  output utu_pkg::result_t            res
);

  logic [1:0]                 bytes_pending, bytes_pending_next;
  logic [utu_pkg::UnitW-1:0]  partial_value, partial_value_next;
  logic [2:0]                 skip_remaining, skip_remaining_next;
  logic [utu_pkg::CountW-1:0] emitted_count, emitted_count_next;
  logic [utu_pkg::UnitW-1:0]  gathered;
  logic [utu_pkg::CountW-1:0] count_inc;
  logic [2:0]                 bad_skip;

  assign count_inc = emitted_count + 16'd1;
  assign gathered  = partial_value |
                     ((bytes_pending == 2'd2) ? {4'd0, byte_in[5:0], 6'd0}
                                              : {10'd0, byte_in[5:0]});

  always_comb begin
    case (byte_in) inside
      [8'hF0:8'hF7]: bad_skip = 3'd3;
      [8'hF8:8'hFB]: bad_skip = 3'd4;
      [8'hFC:8'hFD]: bad_skip = 3'd5;
      8'hFE:         bad_skip = 3'd6;
      8'hFF:         bad_skip = 3'd7;
      default:       bad_skip = 3'd0;
    endcase
  end

  always_comb begin
    bytes_pending_next  = bytes_pending;
    partial_value_next  = partial_value;
    skip_remaining_next = skip_remaining;
    emitted_count_next  = emitted_count;
    res_valid           = 1'b0;
    res.code_unit       = '0;
    res.bad_sequence    = 1'b0;
    res.string_end      = 1'b0;
    res.char_count      = emitted_count;
    if (byte_in == 8'd0) begin
      res_valid           = 1'b1;
      res.string_end      = 1'b1;
      bytes_pending_next  = '0;
      partial_value_next  = '0;
      skip_remaining_next = '0;
      emitted_count_next  = '0;
    end else if (skip_remaining != 3'd0) begin
      skip_remaining_next = skip_remaining - 3'd1;
    end else if (bytes_pending != 2'd0) begin
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        res_valid          = 1'b1;
        res.code_unit      = gathered;
        res.char_count     = count_inc;
        emitted_count_next = count_inc;
        partial_value_next = '0;
      end else begin
        partial_value_next = gathered;
      end
    end else if (emitted_count >= max_chars) begin
      // limit reached: drop
    end else if (!byte_in[7]) begin
      res_valid          = 1'b1;
      res.code_unit      = {8'd0, byte_in};
      res.char_count     = count_inc;
      emitted_count_next = count_inc;
    end else if (byte_in[7:5] == 3'b110) begin
      partial_value_next = {5'd0, byte_in[4:0], 6'd0};
      bytes_pending_next = 2'd1;
    end else if (byte_in[7:4] == 4'b1110) begin
      partial_value_next = {byte_in[3:0], 12'd0};
      bytes_pending_next = 2'd2;
    end else begin
      res_valid           = 1'b1;
      res.code_unit       = utu_pkg::BadUnit;
      res.bad_sequence    = 1'b1;
      res.char_count      = count_inc;
      emitted_count_next  = count_inc;
      skip_remaining_next = bad_skip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending  <= '0;
      partial_value  <= '0;
      skip_remaining <= '0;
      emitted_count  <= '0;
    end else if (step) begin
      bytes_pending  <= bytes_pending_next;
      partial_value  <= partial_value_next;
      skip_remaining <= skip_remaining_next;
      emitted_count  <= emitted_count_next;
    end
  end

endmodule

### rtl/utu_out_reg.sv
// ----------------------------------------------------------------------------
// utu_out_reg
// Result register holding one decoded item until its output transfer.
// ----------------------------------------------------------------------------
module utu_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  utu_pkg::result_t load_data,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output utu_pkg::result_t data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

### rtl/utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream to 16-bit code units, with string end marker and limit.
// Path: each input byte is held in the input register, decoded, and loaded
// into the result register, which drives the output.
// Throughput: one byte per cycle, set by the single decode pass between the
// input register and the result register; a stalled result holds the input.
// Reset: synchronous; clears string state and sets max_chars to 255.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [utu_pkg::CountW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [utu_pkg::ByteW-1:0]   in_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utu_pkg::UnitW-1:0]   code_unit,
  output logic                        bad_sequence,
  output logic                        string_end,
  output logic [utu_pkg::CountW-1:0]  char_count
);

  logic [utu_pkg::CountW-1:0] max_chars;
  logic                       in_full;
  logic [utu_pkg::ByteW-1:0]  in_q;
  logic                       advance;
  logic                       res_valid;
  logic                       out_free;
  utu_pkg::result_t           res;
  utu_pkg::result_t           out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= utu_pkg::MaxCharsReset;
    end else if (cfg_valid) begin
      max_chars <= cfg_data;
    end
  end

  assign advance  = in_full && (!res_valid || out_free);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_byte;
    end
  end

  utu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (in_q),
    .max_chars (max_chars),
    .res_valid (res_valid),
    .res       (res)
  );

  utu_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (out_data)
  );

  assign code_unit    = out_data.code_unit;
  assign bad_sequence = out_data.bad_sequence;
  assign string_end   = out_data.string_end;
  assign char_count   = out_data.char_count;

endmodule
